[sv/fsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the floppy sector command builder
// Holds the command descriptor, error codes, byte positions and the drive
// geometry table.
// ----------------------------------------------------------------------------
package fsc_pkg;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_DRIVE = 2'd1,
    ERR_TYPE  = 2'd2,
    ERR_RANGE = 2'd3
  } err_e;

  typedef enum logic {
    REG_TYPE_CODES = 1'b0,
    REG_READY_MASK = 1'b1
  } reg_e;

  localparam logic [7:0] OPC_MFM      = 8'h40;
  localparam logic [7:0] OPC_READ     = 8'h06;
  localparam logic [7:0] OPC_WRITE    = 8'h05;
  localparam logic [7:0] SIZE_CODE    = 8'd2;
  localparam logic [7:0] GAP3_LEN     = 8'h1B;
  localparam logic [7:0] DATA_LEN     = 8'hFF;

  localparam logic [3:0] POS_OPCODE   = 4'd0;
  localparam logic [3:0] POS_HEADDRV  = 4'd1;
  localparam logic [3:0] POS_CYL      = 4'd2;
  localparam logic [3:0] POS_HEAD     = 4'd3;
  localparam logic [3:0] POS_SECTOR   = 4'd4;
  localparam logic [3:0] POS_SIZE     = 4'd5;
  localparam logic [3:0] POS_SPT      = 4'd6;
  localparam logic [3:0] POS_GAP      = 4'd7;
  localparam logic [3:0] POS_DLEN     = 4'd8;

  // divider steps: cylinder always fits in seven bits
  localparam int unsigned QUO_W = 7;
  localparam logic [2:0]  DIV_LAST = 3'(QUO_W - 1);

  typedef struct packed {
    err_e        err;
    logic        drive;
    logic        wr;
    logic [6:0]  cyl;
    logic        head;
    logic [5:0]  sector;
    logic [5:0]  spt;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [5:0]  spt;
    logic [6:0]  per_cyl;
    logic [12:0] limit;
  } geom_t;

  function automatic geom_t geometry(input logic [3:0] dtype);
    geom_t g;
    g = '0;
    case (dtype)
      4'd1: g = '{ok: 1'b1, spt: 6'd9,  per_cyl: 7'd18, limit: 13'd720};
      4'd2: g = '{ok: 1'b1, spt: 6'd15, per_cyl: 7'd30, limit: 13'd2400};
      4'd3: g = '{ok: 1'b1, spt: 6'd9,  per_cyl: 7'd18, limit: 13'd1440};
      4'd4: g = '{ok: 1'b1, spt: 6'd18, per_cyl: 7'd36, limit: 13'd2880};
      4'd5: g = '{ok: 1'b1, spt: 6'd36, per_cyl: 7'd72, limit: 13'd5760};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

[sv/floppy_sector_command_builder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// floppy_sector_command_builder_top: sector request to controller command
// Requests enter on the s_axis channel, command bytes leave on m_axis.
//
// Each accepted request (drive, block address, read/write) gives the nine
// byte READ DATA or WRITE DATA command, one byte per item, tlast on the
// ninth; a request that cannot be served gives a single zero item with
// tlast and a non-zero error code in tuser.
// A good request passes through a seven-step shift-subtract divider that
// forms the cylinder; a request in error skips it. The byte sequencer
// emits one byte per cycle while m_axis is ready; the divider takes no new
// request until it has formed the descriptor. A two-entry descriptor queue
// sits between intake and sequencer, so new requests are taken while bytes
// wait on a stalled receiver; when m_axis stalls the output item holds and
// intake stops once the queue and the intake output register are full.
// Configuration (drive type codes, ready mask) is to be written through
// cfg_* only while idle; the block itself does not enforce this. Reset
// clears both registers and empties the pipeline.
// ----------------------------------------------------------------------------
module floppy_sector_command_builder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // drive_index, block_address, zero pad
  input  wire logic        s_axis_tuser_i,  // write_request
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // command_byte
  output logic             m_axis_tlast_o,
  output logic [1:0]       m_axis_tuser_o   // error_code
);

  logic          fq_valid, fq_ready;
  fsc_pkg::cmd_t fq_data;
  logic          qb_valid, qb_ready;
  fsc_pkg::cmd_t qb_data;

  fsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .drive_i     (s_axis_tdata_i[1:0]),
    .lba_i       (s_axis_tdata_i[33:2]),
    .wr_i        (s_axis_tuser_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_data)
  );

  fsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_data_o  (qb_data)
  );

  fsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_err_o   (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

[sv/fsc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_front: request intake and address conversion
// Holds the configuration, checks each request and splits the block
// address into cylinder, head and sector with a shift-subtract divider.
// ----------------------------------------------------------------------------
module fsc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire logic [1:0]    drive_i,
  input  wire logic [31:0]   lba_i,
  input  wire logic          wr_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output fsc_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    FE_IDLE = 2'b01,
    FE_DIV  = 2'b10
  } fe_state_e;

  fe_state_e          state_q, state_d;
  logic [7:0]         types_q;
  logic [1:0]         ready_q;
  logic               fv_q, fv_d;
  fsc_pkg::cmd_t      cmd_q, cmd_d;
  logic [12:0]        rem_q, rem_d;
  logic [12:0]        dsh_q, dsh_d;
  logic [6:0]         quo_q, quo_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               drv_q, drv_d;
  logic               wr_q, wr_d;
  logic [5:0]         spt_q, spt_d;

  logic               accept;
  logic [3:0]         dtype;
  fsc_pkg::geom_t     geom;
  fsc_pkg::err_e      err;
  logic               ge;
  logic [12:0]        rem_step;
  logic [6:0]         quo_step;
  logic [6:0]         rem_fin;
  logic               head;
  logic [6:0]         sec_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      types_q <= '0;
      ready_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fsc_pkg::REG_TYPE_CODES: types_q <= cfg_data_i;
        fsc_pkg::REG_READY_MASK: ready_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign req_ready_o = (state_q == FE_IDLE) && (!fv_q || cmd_ready_i);
  assign accept      = req_valid_i && req_ready_o;

  assign dtype = drive_i[0] ? types_q[3:0] : types_q[7:4];
  assign geom  = fsc_pkg::geometry(dtype);

  always_comb begin
    if (drive_i[1] || !ready_q[drive_i[0]]) begin
      err = fsc_pkg::ERR_DRIVE;
    end else if (!geom.ok) begin
      err = fsc_pkg::ERR_TYPE;
    end else if (lba_i >= {19'd0, geom.limit}) begin
      err = fsc_pkg::ERR_RANGE;
    end else begin
      err = fsc_pkg::ERR_OK;
    end
  end

  assign ge       = rem_q >= dsh_q;
  assign rem_step = ge ? (rem_q - dsh_q) : rem_q;
  assign quo_step = {quo_q[5:0], ge};
  assign rem_fin  = rem_step[6:0];
  assign head     = rem_fin >= {1'b0, spt_q};
  assign sec_base = head ? (rem_fin - {1'b0, spt_q}) : rem_fin;

  always_comb begin
    state_d = state_q;
    fv_d    = fv_q;
    cmd_d   = cmd_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    drv_d   = drv_q;
    wr_d    = wr_q;
    spt_d   = spt_q;
    if (fv_q && cmd_ready_i) begin
      fv_d = 1'b0;
    end
    case (state_q)
      FE_IDLE: begin
        if (accept) begin
          if (err != fsc_pkg::ERR_OK) begin
            fv_d      = 1'b1;
            cmd_d     = '0;
            cmd_d.err = err;
          end else begin
            state_d = FE_DIV;
            rem_d   = lba_i[12:0];
            dsh_d   = {geom.per_cyl, 6'd0};
            quo_d   = '0;
            cnt_d   = '0;
            drv_d   = drive_i[0];
            wr_d    = wr_i;
            spt_d   = geom.spt;
          end
        end
      end
      FE_DIV: begin
        rem_d = rem_step;
        quo_d = quo_step;
        dsh_d = {1'b0, dsh_q[12:1]};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == fsc_pkg::DIV_LAST) begin
          state_d      = FE_IDLE;
          fv_d         = 1'b1;
          cmd_d.err    = fsc_pkg::ERR_OK;
          cmd_d.drive  = drv_q;
          cmd_d.wr     = wr_q;
          cmd_d.cyl    = quo_step;
          cmd_d.head   = head;
          cmd_d.sector = sec_base[5:0] + 6'd1;
          cmd_d.spt    = spt_q;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      fv_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fv_q    <= fv_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    drv_q <= drv_d;
    wr_q  <= wr_d;
    spt_q <= spt_d;
  end

  assign cmd_valid_o = fv_q;
  assign cmd_o       = cmd_q;

endmodule
`default_nettype wire

[sv/fsc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_queue: two-entry descriptor queue
// Decouples request intake from byte emission.
// ----------------------------------------------------------------------------
module fsc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fsc_pkg::cmd_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fsc_pkg::cmd_t      out_data_o
);

  fsc_pkg::cmd_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/fsc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_back: command byte sequencer
// Turns each descriptor into the nine command bytes, or one error item,
// through a registered output stage.
// ----------------------------------------------------------------------------
module fsc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire fsc_pkg::cmd_t cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic [1:0]         out_err_o
);

  fsc_pkg::cmd_t cur_q;
  logic          cur_v_q;
  logic [3:0]    idx_q;
  logic          ov_q;
  logic [7:0]    obyte_q;
  logic          olast_q;
  logic [1:0]    oerr_q;

  logic          load_ok;
  logic          emit;
  logic          is_last;
  logic [7:0]    byte_val;

  assign load_ok = !ov_q || out_ready_i;
  assign emit    = cur_v_q && load_ok;
  assign is_last = (cur_q.err != fsc_pkg::ERR_OK) || (idx_q == fsc_pkg::POS_DLEN);
  assign cmd_ready_o = !cur_v_q || (emit && is_last);

  always_comb begin
    case (idx_q)
      fsc_pkg::POS_OPCODE:
        byte_val = fsc_pkg::OPC_MFM | (cur_q.wr ? fsc_pkg::OPC_WRITE : fsc_pkg::OPC_READ);
      fsc_pkg::POS_HEADDRV: byte_val = {5'd0, cur_q.head, 1'b0, cur_q.drive};
      fsc_pkg::POS_CYL:     byte_val = {1'b0, cur_q.cyl};
      fsc_pkg::POS_HEAD:    byte_val = {7'd0, cur_q.head};
      fsc_pkg::POS_SECTOR:  byte_val = {2'd0, cur_q.sector};
      fsc_pkg::POS_SIZE:    byte_val = fsc_pkg::SIZE_CODE;
      fsc_pkg::POS_SPT:     byte_val = {2'd0, cur_q.spt};
      fsc_pkg::POS_GAP:     byte_val = fsc_pkg::GAP3_LEN;
      fsc_pkg::POS_DLEN:    byte_val = fsc_pkg::DATA_LEN;
      default:              byte_val = '0;
    endcase
    if (cur_q.err != fsc_pkg::ERR_OK) begin
      byte_val = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (emit) begin
        ov_q  <= 1'b1;
        idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (cmd_ready_o) begin
        cur_v_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cur_q <= cmd_i;
    end
    if (emit) begin
      obyte_q <= byte_val;
      olast_q <= is_last;
      oerr_q  <= cur_q.err;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_err_o   = oerr_q;

`ifndef SYNTH
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && (oerr_q != fsc_pkg::ERR_OK) |-> olast_q && (obyte_q == 8'd0))
    else $error("error item not a single zero last item");

  a_err_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q && (cur_q.err != fsc_pkg::ERR_OK) |-> idx_q == fsc_pkg::POS_OPCODE)
    else $error("error descriptor mid run");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= fsc_pkg::POS_DLEN)
    else $error("byte position past end of command");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && (cur_q.err == fsc_pkg::ERR_OK) |=> (olast_q == ($past(idx_q) == fsc_pkg::POS_DLEN)))
    else $error("last flag on wrong byte");
`endif

endmodule
`default_nettype wire
